// ===== rtl/md5_pkg.sv =====
// Package: MD5 engine types, constants and round tables.
package md5_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam int BlockWords = 16;
  localparam int WordIdxW = 4;
  localparam int StepCount = 64;
  localparam int StepW = 6;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_COMP,
    ST_OUT
  } md5_state_t;

  typedef struct packed {
    logic       start;
    logic       busy;
    logic       done;
  } md5_comp_ctl_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] w;
    case (i[5:4])
      2'd0: w = i[3:0];
      2'd1: w = 4'(5 * i[3:0] + 1);
      2'd2: w = 4'(3 * i[3:0] + 5);
      default: w = 4'(7 * i[3:0]);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/md5_stream_if.sv =====
// Interfaces: byte input channel and digest output channel.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_item;
  modport source (output valid, data_byte, has_byte, last_item, input ready);
  modport sink (input valid, data_byte, has_byte, last_item, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;
  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

// ===== rtl/md5_round.sv =====
// Compression unit: one MD5 step per cycle, words read from the block memory.
module md5_round (
  input  logic        clk,
  input  logic        rst,
  input  md5_pkg::md5_comp_ctl_t ctl_in,
  output logic        busy,
  output logic        done,
  output logic [3:0]  rd_addr,
  input  logic [31:0] rd_data,
  input  logic [31:0] ch_a,
  input  logic [31:0] ch_b,
  input  logic [31:0] ch_c,
  input  logic [31:0] ch_d,
  output logic [31:0] sum_a,
  output logic [31:0] sum_b,
  output logic [31:0] sum_c,
  output logic [31:0] sum_d
);
  logic [31:0] a, b, c, d;
  logic [5:0]  step;
  logic        run;
  logic        fetch;
  logic [31:0] f, t, sh;
  logic [4:0]  r;

  // memory read runs one step ahead; fetch primes the first word
  assign rd_addr = md5_pkg::word_sel(fetch ? 6'd0 : 6'(step + 6'd1));
  assign busy = run | fetch;

  always_comb begin
    case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = a + f + md5_pkg::sine_k(step) + rd_data;
    r = md5_pkg::rot_amt(step);
    sh = (t << r) | (t >> (6'd32 - {1'b0, r}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fetch <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        fetch <= 1'b1;
        step <= '0;
        a <= ch_a; b <= ch_b; c <= ch_c; d <= ch_d;
      end else if (fetch) begin
        fetch <= 1'b0;
        run <= 1'b1;
      end else if (run) begin
        a <= d; d <= c; c <= b;
        b <= b + (r == 5'd0 ? t : sh);
        step <= step + 6'd1;
        if (step == 6'(md5_pkg::StepCount - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sum_a = ch_a + a;
  assign sum_b = ch_b + b;
  assign sum_c = ch_c + c;
  assign sum_d = ch_d + d;

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(ctl_in.start && busy)) else $error("start while busy");
    end
  end
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run)) else $error("done without run");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(run && fetch)) else $error("run and fetch overlap");
endmodule

// ===== rtl/md5_digest_engine.sv =====
// Top level: MD5 engine with block memory, controller and step unit.
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | data_byte, has_byte, last_item
//  out_ch  | out | valid/ready | digest_a..digest_d
// A byte that ends neither a block nor a message leaves the engine idle and ready for the next.
// A full block in the step unit is one fetch, 64 steps and one add back.
// A last item adds up to 18 pad/zero/length word writes and one or two blocks.
// Reset loads the initial chaining words and clears the bit count; the block memory is not cleared.
// Input ready is high only in idle: low while padding, compressing or a digest waits on out_ch.
module md5_digest_engine (
  input logic clk,
  input logic rst,
  md5_in_if.sink in_ch,
  md5_out_if.source out_ch
);
  logic [31:0] mem [md5_pkg::BlockWords];
  logic [31:0] rd_data;
  logic [3:0]  rd_addr, crd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [31:0] cur_word;

  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] s_a, s_b, s_c, s_d;
  logic [63:0] bit_cnt;
  logic        last_pend;
  logic        padded;
  logic        second;
  logic [3:0]  fill;
  md5_pkg::md5_state_t state, state_next;
  md5_pkg::md5_comp_ctl_t ctl;
  logic        cbusy, cdone;
  logic [5:0]  pos;
  logic        accept;

  assign pos = bit_cnt[8:3];
  assign accept = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state == md5_pkg::ST_IDLE);

  // word being built; lanes above the current byte are zero
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
  assign rd_addr = crd_addr;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos[5:2];
    wr_data = '0;
    case (state)
      md5_pkg::ST_IDLE: begin
        if (accept && in_ch.has_byte) begin
          wr_en = 1'b1;
          wr_data = ((pos[1:0] == 2'd0) ? 32'd0 : cur_word)
                  | ({24'd0, in_ch.data_byte} << {pos[1:0], 3'd0});
        end
      end
      md5_pkg::ST_PAD: begin
        wr_en = 1'b1;
        wr_data = ((pos[1:0] == 2'd0) ? 32'd0 : cur_word)
                | ({24'd0, md5_pkg::PadByte} << {pos[1:0], 3'd0});
      end
      md5_pkg::ST_ZERO: begin
        wr_en = 1'b1;
        wr_addr = fill;
      end
      md5_pkg::ST_LEN_LO: begin
        wr_en = 1'b1;
        wr_addr = 4'd14;
        wr_data = bit_cnt[31:0];
      end
      md5_pkg::ST_LEN_HI: begin
        wr_en = 1'b1;
        wr_addr = 4'd15;
        wr_data = bit_cnt[63:32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == md5_pkg::ST_IDLE && accept && in_ch.has_byte)
      cur_word <= (pos[1:0] == 2'd0) ? {24'd0, in_ch.data_byte}
                : cur_word | ({24'd0, in_ch.data_byte} << {pos[1:0], 3'd0});
  end

  always_comb begin
    state_next = state;
    case (state)
      md5_pkg::ST_IDLE:
        if (accept) begin
          if (in_ch.has_byte && pos == 6'd63) state_next = md5_pkg::ST_COMP;
          else if (in_ch.last_item) state_next = md5_pkg::ST_PAD;
        end
      md5_pkg::ST_PAD: state_next = (pos[5:2] == 4'd15) ? md5_pkg::ST_COMP
                                                           : md5_pkg::ST_ZERO;
      md5_pkg::ST_ZERO:
        if (fill >= 4'd13 && !second) state_next = md5_pkg::ST_LEN_LO;
        else if (fill == 4'd15) state_next = md5_pkg::ST_COMP;
      md5_pkg::ST_LEN_LO: state_next = md5_pkg::ST_LEN_HI;
      md5_pkg::ST_LEN_HI: state_next = md5_pkg::ST_COMP;
      md5_pkg::ST_COMP:
        if (cdone) begin
          if (!last_pend) state_next = md5_pkg::ST_IDLE;
          else if (!padded) state_next = md5_pkg::ST_PAD;
          else if (second) state_next = md5_pkg::ST_ZERO;
          else state_next = md5_pkg::ST_OUT;
        end
      md5_pkg::ST_OUT: if (out_ch.ready) state_next = md5_pkg::ST_IDLE;
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.start = (state != md5_pkg::ST_COMP) && (state_next == md5_pkg::ST_COMP);
    ctl.busy = cbusy;
    ctl.done = cdone;
  end

  md5_round u_round (
    .clk(clk), .rst(rst), .ctl_in(ctl), .busy(cbusy), .done(cdone),
    .rd_addr(crd_addr), .rd_data(rd_data),
    .ch_a(ch_a), .ch_b(ch_b), .ch_c(ch_c), .ch_d(ch_d),
    .sum_a(s_a), .sum_b(s_b), .sum_c(s_c), .sum_d(s_d)
  );

  // second: set when padding spilled past the length slot (zero a second block)
  // last_pend: a final item is in progress; padded: its pad byte is written
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::ST_IDLE;
      ch_a <= md5_pkg::IvA; ch_b <= md5_pkg::IvB;
      ch_c <= md5_pkg::IvC; ch_d <= md5_pkg::IvD;
      bit_cnt <= '0;
      last_pend <= 1'b0;
      padded <= 1'b0;
      second <= 1'b0;
      fill <= '0;
    end else begin
      state <= state_next;
      case (state)
        md5_pkg::ST_IDLE:
          if (accept) begin
            if (in_ch.has_byte) bit_cnt <= bit_cnt + 64'd8;
            last_pend <= in_ch.last_item;
            padded <= 1'b0;
            second <= 1'b0;
          end
        md5_pkg::ST_PAD: begin
          fill <= pos[5:2] + 4'd1;
          second <= (pos >= md5_pkg::LenPos);
          padded <= 1'b1;
        end
        md5_pkg::ST_ZERO: fill <= fill + 4'd1;
        md5_pkg::ST_COMP:
          if (cdone) begin
            ch_a <= s_a; ch_b <= s_b; ch_c <= s_c; ch_d <= s_d;
            if (second) begin
              second <= 1'b0;
              fill <= '0;
            end
          end
        md5_pkg::ST_OUT:
          if (out_ch.ready) begin
            ch_a <= md5_pkg::IvA; ch_b <= md5_pkg::IvB;
            ch_c <= md5_pkg::IvC; ch_d <= md5_pkg::IvD;
            bit_cnt <= '0;
            last_pend <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_ch.valid = (state == md5_pkg::ST_OUT);
    out_ch.digest_a = ch_a;
    out_ch.digest_b = ch_b;
    out_ch.digest_c = ch_c;
    out_ch.digest_d = ch_d;
  end

  a_out_only_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> last_pend) else $error("digest without final item");
  a_idle_no_comp: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_IDLE) |-> !cbusy) else $error("step unit busy in idle");
  a_reset_iv: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> (ch_a == md5_pkg::IvA && bit_cnt == 64'd0))
    else $error("chain not reinitialized");
endmodule

// ===== dv/tb_md5_digest_engine.sv =====
// Testbench: MD5 engine byte stream checked against a behavioral digest predictor.
module tb_md5_digest_engine;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
    logic       check_fixed;
    logic [127:0] fixed_digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  md5_in_if in_ch ();
  md5_out_if out_ch ();

  md5_digest_engine u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #10 clk = ~clk;

  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] blk [16];
  logic [63:0] bit_cnt;
  digest_t digest_q[$];
  int mismatches = 0;
  int digests_seen = 0;
  int items_sent = 0;

  localparam logic [31:0] SineTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RotTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  localparam int OvfLens [4] = '{55, 56, 63, 64};

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t, sum;
    int w, rnd;
    a = ch_a; b = ch_b; c = ch_c; d = ch_d;
    for (int s = 0; s < 64; s++) begin
      rnd = s / 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); w = s; end
        1: begin f = (b & d) | (c & ~d); w = (5 * s + 1) % 16; end
        2: begin f = b ^ c ^ d; w = (3 * s + 5) % 16; end
        default: begin f = c ^ (b | ~d); w = (7 * s) % 16; end
      endcase
      t = d;
      sum = a + f + SineTab[s] + blk[w];
      d = c;
      c = b;
      b = b + rotl(sum, RotTab[rnd * 4 + s % 4]);
      a = t;
    end
    ch_a += a; ch_b += b; ch_c += c; ch_d += d;
  endtask

  task automatic place_byte(int pos, logic [7:0] v);
    if (pos % 4 == 0) blk[pos / 4] = {24'h0, v};
    else blk[pos / 4] |= 32'(v) << (8 * (pos % 4));
  endtask

  task automatic chain_init();
    ch_a = md5_pkg::IvA; ch_b = md5_pkg::IvB; ch_c = md5_pkg::IvC; ch_d = md5_pkg::IvD;
    bit_cnt = '0;
  endtask

  task automatic predict_digest(logic [7:0] db, logic hb, logic li);
    int pos;
    if (hb) begin
      pos = bit_cnt[8:3];
      place_byte(pos, db);
      bit_cnt += 8;
      if (pos == 63) compress_block();
    end
    if (li) begin
      pos = bit_cnt[8:3];
      place_byte(pos, 8'h80);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 14; i++) blk[i] = '0;
      end
      blk[14] = bit_cnt[31:0];
      blk[15] = bit_cnt[63:32];
      compress_block();
      digest_q.push_back({ch_a, ch_b, ch_c, ch_d});
      chain_init();
    end
  endtask

  // Directed rows; fixed digests for empty message and "abc"
  localparam int NumDirected = 12;
  stim_row_t dir_tab [NumDirected];
  initial begin
    dir_tab[0] = {8'h00, 1'b0, 1'b1, 1'b1, 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec};
    dir_tab[1] = {8'h61, 1'b1, 1'b0, 1'b0, 128'h0};
    dir_tab[2] = {8'h62, 1'b1, 1'b0, 1'b0, 128'h0};
    dir_tab[3] = {8'h00, 1'b0, 1'b0, 1'b0, 128'h0};
    dir_tab[4] = {8'h63, 1'b1, 1'b1, 1'b1, 128'h98500190_b04fd23c_7d3f96d6_727fe128};
    dir_tab[5] = {8'hff, 1'b1, 1'b1, 1'b0, 128'h0};
    dir_tab[6] = {8'h00, 1'b1, 1'b1, 1'b0, 128'h0};
    dir_tab[7] = {8'hff, 1'b1, 1'b0, 1'b0, 128'h0};
    dir_tab[8] = {8'h00, 1'b1, 1'b0, 1'b0, 128'h0};
    dir_tab[9] = {8'h55, 1'b0, 1'b1, 1'b0, 128'h0};
    dir_tab[10] = {8'haa, 1'b1, 1'b0, 1'b0, 128'h0};
    dir_tab[11] = {8'h00, 1'b0, 1'b1, 1'b0, 128'h0};
  end

  digest_t fixed_q[$];
  logic    fixed_use_q[$];

  task automatic send_item(logic [7:0] db, logic hb, logic li);
    in_ch.data_byte <= db;
    in_ch.has_byte <= hb;
    in_ch.last_item <= li;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(db, hb, li);
    items_sent++;
    @(negedge clk);
  endtask

  int burst_left = 0;
  task automatic send_paced(logic [7:0] db, logic hb, logic li);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(db, hb, li);
  endtask

  // Message lengths cluster near the padding boundaries
  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++)
      send_paced(8'($urandom_range(0, 255)), 1'b1, (!empty_end && i == len - 1));
    if (empty_end || len == 0) send_paced(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  int len;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.last_item = 1'b0;
    chain_init();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < NumDirected; r++) begin
      if (dir_tab[r].last_item) begin
        fixed_use_q.push_back(dir_tab[r].check_fixed);
        fixed_q.push_back(dir_tab[r].fixed_digest);
      end
      send_paced(dir_tab[r].data_byte, dir_tab[r].has_byte, dir_tab[r].last_item);
    end
    // block-full then last, padding overflow at 55/56/63/64
    foreach (OvfLens[k]) begin
      fixed_use_q.push_back(1'b0); fixed_q.push_back('0);
      send_message(OvfLens[k], 1'(k % 2));
    end
    while (items_sent < 450) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(52, 66);
        2: len = $urandom_range(116, 130);
        default: len = $urandom_range(0, 20);
      endcase
      if ($urandom_range(0, 7) == 0) send_paced(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      fixed_use_q.push_back(1'b0); fixed_q.push_back('0);
      send_message(len, $urandom_range(0, 3) == 0);
    end
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  int stall_ctr = 0;
  always @(negedge clk) begin
    stall_ctr <= stall_ctr + 1;
    out_ch.ready <= rst ? 1'b0 : !(stall_ctr % 37 < 9 || $urandom_range(0, 3) == 0);
  end
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    digest_t got, want;
    logic use_fixed;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.digest_a, out_ch.digest_b, out_ch.digest_c, out_ch.digest_d};
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest transfer %h", got);
      end else begin
        want = digest_q.pop_front();
        use_fixed = fixed_use_q.size() ? fixed_use_q.pop_front() : 1'b0;
        if (fixed_q.size()) begin
          if (use_fixed) want = fixed_q[0];
          void'(fixed_q.pop_front());
        end
        if (got.a !== want.a || got.b !== want.b || got.c !== want.c || got.d !== want.d) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h %h %h %h actual %h %h %h %h",
                     want.a, want.b, want.c, want.d, got.a, got.b, got.c, got.d);
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
